// ----- sv/csv_pkg.sv -----
// shared types and constants for the cube sphere vertex and index generator
package csv_pkg;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_INDEX  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  localparam logic CFG_RESOLUTION = 1'b0;
  localparam logic CFG_RADIUS     = 1'b1;

  localparam logic [8:0]  RES_RESET    = 9'd10;
  localparam logic [15:0] RADIUS_RESET = 16'd256;

  localparam int NW       = 20;
  localparam int SQRT_W   = 25;
  localparam int DIV_W    = 17;
  localparam int NUM_W    = 41;

  typedef struct packed {
    logic [2:0] face;
    logic [7:0] grid_x;
    logic [7:0] grid_y;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic [18:0]        vertex_index;
    logic               last;
  } out_t;

  typedef struct packed {
    logic               reject;
    logic               edge_pt;
    logic signed [9:0]  p_x;
    logic signed [9:0]  p_y;
    logic signed [9:0]  p_z;
    logic [NW-1:0]      norm2;
    logic [18:0]        base;
    logic [8:0]         res;
  } work_t;

endpackage

// ----- sv/csv_fifo.sv -----
// small first-in first-out queue of packed items
module csv_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/csv_front.sv -----
// front end: clamps resolution, rejects bad points, forms the cube point and index base
module csv_front #(
  parameter int MAX_RESOLUTION = 256
) (
  input  csv_pkg::in_t   item_i,
  input  logic [8:0]     res_i,
  output csv_pkg::work_t work_o
);
  import csv_pkg::*;

  localparam logic [9:0] MaxR = (MAX_RESOLUTION > 511) ? 10'd511 : 10'(MAX_RESOLUTION);

  logic [9:0]        r10;
  logic [8:0]        r;
  logic signed [9:0] d, u, v;
  logic [19:0]       dd, uu, vv;
  logic [17:0]       rr;
  logic [20:0]       base_full;

  always_comb begin
    r10 = {1'b0, res_i};
    if (r10 < 10'd2) begin
      r10 = 10'd2;
    end
    if (r10 > MaxR) begin
      r10 = MaxR;
    end
    r = r10[8:0];
    d = $signed({1'b0, r}) - 10'sd1;
    u = $signed({1'b0, item_i.grid_x, 1'b0}) - d;
    v = $signed({1'b0, item_i.grid_y, 1'b0}) - d;
    dd = 20'(d * d);
    uu = 20'(u * u);
    vv = 20'(v * v);
    rr = 18'(r * r);

    work_o = '0;
    work_o.reject  = (item_i.face > 3'd5) || ({1'b0, item_i.grid_x} >= r)
                     || ({1'b0, item_i.grid_y} >= r);
    work_o.edge_pt = ({1'b0, item_i.grid_x} == r - 9'd1)
                     || ({1'b0, item_i.grid_y} == r - 9'd1);
    work_o.norm2   = dd + uu + vv;
    work_o.res     = r;
    base_full      = 21'(item_i.grid_x) + 21'(item_i.grid_y * r) + 21'(rr * item_i.face);
    work_o.base    = base_full[18:0];
    case (item_i.face)
      3'd0: begin
        work_o.p_x = d;  work_o.p_y = -v; work_o.p_z = u;
      end
      3'd1: begin
        work_o.p_x = -d; work_o.p_y = -v; work_o.p_z = -u;
      end
      3'd2: begin
        work_o.p_x = u;  work_o.p_y = d;  work_o.p_z = -v;
      end
      3'd3: begin
        work_o.p_x = -u; work_o.p_y = -d; work_o.p_z = -v;
      end
      3'd4: begin
        work_o.p_x = -v; work_o.p_y = u;  work_o.p_z = d;
      end
      3'd5: begin
        work_o.p_x = -v; work_o.p_y = -u; work_o.p_z = -d;
      end
      default: begin
        work_o.p_x = '0; work_o.p_y = '0; work_o.p_z = '0;
      end
    endcase
  end

endmodule

// ----- sv/csv_back.sv -----
// back end: square root, three dividers, radius scaling and result sequencing
module csv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    radius_i,
  input  logic           work_empty_i,
  input  csv_pkg::work_t work_i,
  output logic           work_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output csv_pkg::out_t  res_o
);
  import csv_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_DIV, ST_SCALE, ST_VERT, ST_IDX, ST_REJ
  } state_e;

  state_e            st_q;
  work_t             w_q;
  logic [49:0]       m_q;
  logic [26:0]       srem_q;
  logic [SQRT_W-1:0] root_q;
  logic [4:0]        cnt_q;
  logic [NUM_W-1:0]  dnum_q [3];
  logic [25:0]       drem_q [3];
  logic [DIV_W-1:0]  quo_q  [3];
  logic              neg_q  [3];
  logic [23:0]       crd_q  [3];

  logic [28:0]       s_t, s_trial;
  logic [SQRT_W-1:0] len;
  logic [25:0]       dvs;
  logic [26:0]       d_t [3];
  logic signed [9:0] pc [3];
  logic [9:0]        mag [3];
  logic [NUM_W-1:0]  num0 [3];
  logic [15:0]       qs [3];
  logic [32:0]       prod [3];
  logic [23:0]       cmag [3];
  logic [18:0]       idx;

  assign work_pop_o = (st_q == ST_IDLE) && !work_empty_i;
  assign res_push_o = ((st_q == ST_VERT) || (st_q == ST_IDX) || (st_q == ST_REJ)) && !res_full_i;

  always_comb begin
    s_t     = {srem_q, m_q[49:48]};
    s_trial = {2'b00, root_q, 2'b01};
    len     = (root_q == '0) ? SQRT_W'(1) : root_q;
    dvs     = {len, 1'b0};
    pc[0]   = w_q.p_x;
    pc[1]   = w_q.p_y;
    pc[2]   = w_q.p_z;
    for (int i = 0; i < 3; i++) begin
      mag[i]  = pc[i][9] ? 10'(-pc[i]) : pc[i];
      num0[i] = {mag[i], 31'b0} + NUM_W'(len);
      d_t[i]  = {drem_q[i], dnum_q[i][NUM_W-1]};
      if (neg_q[i]) begin
        qs[i] = (quo_q[i] > 17'd32768) ? 16'd32768 : quo_q[i][15:0];
      end else begin
        qs[i] = (quo_q[i] > 17'd32767) ? 16'd32767 : quo_q[i][15:0];
      end
      prod[i] = 33'(qs[i] * radius_i) + 33'd128;
      cmag[i] = prod[i][31:8];
    end
    case (cnt_q[2:0])
      3'd1:    idx = w_q.base + 19'(w_q.res);
      3'd2:    idx = w_q.base + 19'(w_q.res) + 19'd1;
      3'd4:    idx = w_q.base + 19'(w_q.res) + 19'd1;
      3'd5:    idx = w_q.base + 19'd1;
      default: idx = w_q.base;
    endcase
    res_o = '0;
    case (st_q)
      ST_VERT: begin
        res_o.kind    = KIND_VERTEX;
        res_o.coord_x = crd_q[0];
        res_o.coord_y = crd_q[1];
        res_o.coord_z = crd_q[2];
        res_o.last    = w_q.edge_pt;
      end
      ST_IDX: begin
        res_o.kind         = KIND_INDEX;
        res_o.vertex_index = idx;
        res_o.last         = (cnt_q == 5'd5);
      end
      ST_REJ: begin
        res_o.kind = KIND_REJECT;
        res_o.last = 1'b1;
      end
      default: res_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      w_q    <= '0;
      m_q    <= '0;
      srem_q <= '0;
      root_q <= '0;
      for (int i = 0; i < 3; i++) begin
        dnum_q[i] <= '0;
        drem_q[i] <= '0;
        quo_q[i]  <= '0;
        neg_q[i]  <= 1'b0;
        crd_q[i]  <= '0;
      end
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (!work_empty_i) begin
            w_q    <= work_i;
            m_q    <= {work_i.norm2, 30'b0};
            srem_q <= '0;
            root_q <= '0;
            cnt_q  <= 5'(SQRT_W - 1);
            st_q   <= work_i.reject ? ST_REJ : ST_SQRT;
          end
        end
        ST_SQRT: begin
          m_q <= {m_q[47:0], 2'b00};
          if (s_t >= s_trial) begin
            srem_q <= 27'(s_t - s_trial);
            root_q <= {root_q[SQRT_W-2:0], 1'b1};
          end else begin
            srem_q <= s_t[26:0];
            root_q <= {root_q[SQRT_W-2:0], 1'b0};
          end
          if (cnt_q == '0) begin
            st_q  <= ST_DIV;
            cnt_q <= 5'(DIV_W);
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (cnt_q == 5'(DIV_W)) begin
              neg_q[i]  <= pc[i][9];
              drem_q[i] <= {2'b00, num0[i][NUM_W-1:DIV_W]};
              dnum_q[i] <= {num0[i][DIV_W-1:0], 24'b0};
              quo_q[i]  <= '0;
            end else begin
              dnum_q[i] <= {dnum_q[i][NUM_W-2:0], 1'b0};
              if (d_t[i] >= {1'b0, dvs}) begin
                drem_q[i] <= 26'(d_t[i] - {1'b0, dvs});
                quo_q[i]  <= {quo_q[i][DIV_W-2:0], 1'b1};
              end else begin
                drem_q[i] <= d_t[i][25:0];
                quo_q[i]  <= {quo_q[i][DIV_W-2:0], 1'b0};
              end
            end
          end
          if (cnt_q == '0) begin
            st_q <= ST_SCALE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_SCALE: begin
          for (int i = 0; i < 3; i++) begin
            crd_q[i] <= neg_q[i] ? 24'(-cmag[i]) : cmag[i];
          end
          st_q <= ST_VERT;
        end
        ST_VERT: begin
          if (!res_full_i) begin
            cnt_q <= '0;
            st_q  <= w_q.edge_pt ? ST_IDLE : ST_IDX;
          end
        end
        ST_IDX: begin
          if (!res_full_i) begin
            if (cnt_q == 5'd5) begin
              st_q <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_REJ: begin
          if (!res_full_i) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (root_q != '0))
    else $error("square root is zero at divide");
  a_idx_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDX && res_push_o && cnt_q == 5'd5) |=> (st_q == ST_IDLE))
    else $error("index run did not end after six transfers");
  a_scale_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCALE) |=> (st_q == ST_VERT))
    else $error("scaling not followed by vertex transfer");

endmodule

// ----- sv/cube_sphere_vertex_index_gen_core.sv -----
// top level of the cube sphere vertex and index generator
// a rejected point gives a single reject result; a vertex item passes the root steps,
// the divide steps and a scale step, then gives its vertex result and six index results,
// or the vertex result alone at the grid edge; the back end takes no new item until done
// queues of two entries sit on both sides
// reset: asynchronous active low, queues empty, resolution 10, radius 256
module cube_sphere_vertex_index_gen_core #(
  parameter int MAX_RESOLUTION = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  csv_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output csv_pkg::out_t res_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);
  import csv_pkg::*;

  logic [8:0]  res_q;
  logic [15:0] rad_q;
  work_t       front_work, q_work;
  logic        wq_empty, wq_pop, res_full, res_push;
  out_t        back_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= RES_RESET;
      rad_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_RESOLUTION) begin
        res_q <= cfg_data_i[8:0];
      end else begin
        rad_q <= cfg_data_i;
      end
    end
  end

  csv_front #(.MAX_RESOLUTION(MAX_RESOLUTION)) u_front (
    .item_i (in_data_i),
    .res_i  (res_q),
    .work_o (front_work)
  );

  csv_fifo #(.T(work_t), .DEPTH(2)) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_work),
    .full_o  (full),
    .pop_i   (wq_pop),
    .empty_o (wq_empty),
    .data_o  (q_work)
  );

  csv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radius_i     (rad_q),
    .work_empty_i (wq_empty),
    .work_i       (q_work),
    .work_pop_o   (wq_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  csv_fifo #(.T(out_t), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_data_o)
  );

endmodule
